// ----- hw/rtl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define B64D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Expression must never be true outside reset.
`define B64D_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ----- hw/rtl/b64d_pkg.sv -----
// -----------------------------------------------------------------------------
// Base64 decoder package
// Shared types and constants of the base64 stream decoder.
// -----------------------------------------------------------------------------
package b64d_pkg;

  // Decoupling queue between the classifier and the decoder.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Alphabet offsets of the standard alphabet.
  localparam logic [5:0] LowerBase = 6'd26;
  localparam logic [5:0] DigitBase = 6'd52;
  localparam logic [5:0] PlusCode  = 6'd62;
  localparam logic [5:0] SlashCode = 6'd63;

  // Class of one incoming character.
  typedef enum logic [1:0] {
    KIND_SPACE,
    KIND_PAD,
    KIND_BAD,
    KIND_DATA
  } kind_e;

  // Reported decoder status.
  typedef enum logic [1:0] {
    ST_DECODING = 2'd0,
    ST_PADDED   = 2'd1,
    ST_BAD      = 2'd2
  } status_e;

  // One classified character as it travels through the queue.
  typedef struct packed {
    kind_e      kind;
    logic [5:0] sextet;
    logic       last;
  } cls_t;

endpackage

// ----- hw/rtl/b64d_front.sv -----
// -----------------------------------------------------------------------------
// Base64 decoder front end
// Accepts characters and classifies them into whitespace, padding, bad or data.
// -----------------------------------------------------------------------------
module b64d_front (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_char_i,
  input  logic            last_char_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output b64d_pkg::cls_t  q_data_o
);
  import b64d_pkg::*;

  logic [7:0] ch;

  assign ch         = in_char_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o.last   = last_char_i;
    q_data_o.sextet = '0;
    q_data_o.kind   = KIND_BAD;
    if (ch == 8'h0D || ch == 8'h0A || ch == 8'h20 || ch == 8'h09) begin
      q_data_o.kind = KIND_SPACE;
    end else if (ch == 8'h3D) begin
      q_data_o.kind = KIND_PAD;
    end else if (ch >= 8'h41 && ch <= 8'h5A) begin
      q_data_o.kind   = KIND_DATA;
      q_data_o.sextet = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      q_data_o.kind   = KIND_DATA;
      q_data_o.sextet = 6'(ch - 8'h61) + LowerBase;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      q_data_o.kind   = KIND_DATA;
      q_data_o.sextet = 6'(ch - 8'h30) + DigitBase;
    end else if (ch == 8'h2B) begin
      q_data_o.kind   = KIND_DATA;
      q_data_o.sextet = PlusCode;
    end else if (ch == 8'h2F) begin
      q_data_o.kind   = KIND_DATA;
      q_data_o.sextet = SlashCode;
    end
  end

endmodule

// ----- hw/rtl/b64d_queue.sv -----
// -----------------------------------------------------------------------------
// Base64 decoder queue
// Short FIFO of classified characters between the front and back ends.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64d_pkg::cls_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output b64d_pkg::cls_t  pop_data_o
);
  import b64d_pkg::*;

  cls_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `B64D_NEVER(q_no_overflow, push_i && full_o, "queue written while full")
  `B64D_NEVER(q_no_underflow, pop_i && !valid_o, "queue read while empty")

endmodule

// ----- hw/rtl/b64d_back.sv -----
// -----------------------------------------------------------------------------
// Base64 decoder back end
// Holds the bit accumulator and message flags and registers each result.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  b64d_pkg::cls_t  q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic [1:0]      status_o,
  output logic            end_of_message_o
);
  import b64d_pkg::*;

  logic [5:0]  acc_q, acc_d;
  logic [2:0]  held_q, held_d;
  logic        pad_q, pad_d;
  logic        err_q, err_d;
  logic        out_valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        bvalid_q, bvalid_d;
  status_e     status_q, status_d;
  logic        eom_q;
  logic [11:0] wide;

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);
  assign wide    = {acc_q, q_data_i.sextet};

  always_comb begin
    acc_d    = acc_q;
    held_d   = held_q;
    pad_d    = pad_q;
    err_d    = err_q;
    byte_d   = '0;
    bvalid_d = 1'b0;
    if (!pad_q && !err_q) begin
      unique case (q_data_i.kind)
        KIND_SPACE: ;
        KIND_PAD:   pad_d = 1'b1;
        KIND_BAD:   err_d = 1'b1;
        KIND_DATA: begin
          // Six new bits join the leftovers; a byte leaves once eight are held.
          unique case (held_q)
            3'd2: begin
              byte_d   = wide[7:0];
              bvalid_d = 1'b1;
              acc_d    = '0;
              held_d   = 3'd0;
            end
            3'd4: begin
              byte_d   = wide[9:2];
              bvalid_d = 1'b1;
              acc_d    = {4'b0, wide[1:0]};
              held_d   = 3'd2;
            end
            3'd6: begin
              byte_d   = wide[11:4];
              bvalid_d = 1'b1;
              acc_d    = {2'b0, wide[3:0]};
              held_d   = 3'd4;
            end
            default: begin
              acc_d  = q_data_i.sextet;
              held_d = 3'd6;
            end
          endcase
        end
        default: ;
      endcase
    end
    if (err_d) begin
      status_d = ST_BAD;
    end else if (pad_d) begin
      status_d = ST_PADDED;
    end else begin
      status_d = ST_DECODING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      held_q      <= '0;
      pad_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
        if (q_data_i.last) begin
          acc_q  <= '0;
          held_q <= '0;
          pad_q  <= 1'b0;
          err_q  <= 1'b0;
        end else begin
          acc_q  <= acc_d;
          held_q <= held_d;
          pad_q  <= pad_d;
          err_q  <= err_d;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      byte_q   <= byte_d;
      bvalid_q <= bvalid_d;
      status_q <= status_d;
      eom_q    <= q_data_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = byte_q;
  assign byte_valid_o     = bvalid_q;
  assign status_o         = status_q;
  assign end_of_message_o = eom_q;

  `B64D_ASSERT(back_held_even, !held_q[0], "odd number of bits held")
  `B64D_ASSERT(back_clear_after_last, q_pop_o && q_data_i.last |=>
    held_q == '0 && acc_q == '0 && !pad_q && !err_q, "state not cleared at message end")

endmodule

// ----- hw/rtl/base64_stream_decoder_unit.sv -----
// -----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes standard-alphabet base64 text, one character per transaction.
// -----------------------------------------------------------------------------
//
//   Channel | Handshake                | Payload
//   --------+--------------------------+---------------------------------------
//   input   | in_valid_i / in_stall_o  | in_char_i, last_char_i
//   output  | out_valid_o / out_stall_i| out_byte_o, byte_valid_o, status_o,
//           |                          | end_of_message_o
//
// Every input transaction produces exactly one output transaction; it passes
// through the classifier queue and then the output register. One character
// per cycle is sustained while the output is not stalled; the accumulator
// update in the back end is the recurrence that sets this figure.
// Reset is asynchronous and active low; it clears the queue, the accumulator,
// the padding and error flags, and the output valid.
// An output stall holds the result register; the two-entry queue keeps
// accepting until full, and then in_stall_o rises.
//
// The front end only classifies characters (whitespace, padding, bad, data with
// its 6-bit value). The back end owns all message state, so a character's effect
// depends only on what the back end has already consumed. A last character
// returns the state to its reset value after its own result is formed.
module base64_stream_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] status_o,
  output logic       end_of_message_o
);
  import b64d_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cls_t push_data;
  cls_t pop_data;

  // Classify the incoming character.
  b64d_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_char_i   (in_char_i),
    .last_char_i (last_char_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (push_data)
  );

  // Decouple the two sides so each can stall on its own.
  b64d_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  // Accumulate sextets, emit bytes and track padding and errors.
  b64d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (pop_data),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .status_o         (status_o),
    .end_of_message_o (end_of_message_o)
  );

endmodule
